// ===== hdl/pckt_pkg.sv =====
// Shared types and codes for the packed counted key table.
package pckt_pkg;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Fixed field widths of the item channels.
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned USED_W   = 5;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CMP,
    OP_INC,
    OP_SUB,
    OP_SHIFT,
    OP_APPEND
  } cell_op_t;

  // Control group sent from the sequencer to the cells.
  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  // Input item.
  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
  } in_t;

  // Result item.
  typedef struct packed {
    logic                ok;
    logic [COUNT_W-1:0]  count;
    logic [USED_W-1:0]   used;
    logic                full_res;
  } out_t;

endpackage

// ===== hdl/pckt_cell.sv =====
// One slot of the table: key, count, match flag and links to its neighbors.
module pckt_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned UW         = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pckt_pkg::cell_ctl_t   ctl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [COUNT_BITS-1:0] amount,
  input  logic [UW-1:0]         used,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [COUNT_BITS-1:0] next_count,
  input  logic                  seen_in,
  input  logic [COUNT_BITS-1:0] cnt_in,
  output logic [KEY_BITS-1:0]   key_out,
  output logic [COUNT_BITS-1:0] count_out,
  output logic                  seen_out,
  output logic [COUNT_BITS-1:0] cnt_out
);

  localparam logic [UW-1:0] MY_IDX = UW'(IDX);

  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   key_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  hit_r;
  logic                  hit_nxt;
  logic                  occupied;

  // A slot below the fill level holds live data.
  assign occupied = (MY_IDX < used);

  // Next state of the slot for the broadcast operation.
  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    unique case (ctl.op)
      pckt_pkg::OP_CMP: begin
        hit_nxt = occupied && (key_r == cmp_key);
      end
      pckt_pkg::OP_INC: begin
        if (hit_r) begin
          count_nxt = count_r + 1'b1;
        end
      end
      pckt_pkg::OP_SUB: begin
        if (hit_r) begin
          count_nxt = count_r - amount;
        end
      end
      pckt_pkg::OP_SHIFT: begin
        // The emptied slot and every slot after it take the next slot's data.
        if (seen_in || hit_r) begin
          key_nxt   = next_key;
          count_nxt = next_count;
        end
      end
      pckt_pkg::OP_APPEND: begin
        if (MY_IDX == used) begin
          key_nxt   = cmp_key;
          count_nxt = COUNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Slot contents carry no reset; the match flag does.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  // Neighbor links and the gathered count of the matching slot.
  assign key_out   = key_r;
  assign count_out = count_r;
  assign seen_out  = seen_in || hit_r;
  assign cnt_out   = cnt_in | (hit_r ? count_r : '0);

endmodule

// ===== hdl/packed_counted_key_table_unit.sv =====
// Top level of the packed counted key table: sequencer, row of slot cells, result register.
// An item is compared in every cell as it is accepted; in S_EXEC the cell row is then updated
// or shifted down and the result registered, with S_EXEC held while a result is stalled.
// A new item is taken only in S_IDLE, so not before the previous result is registered.
// Reset: synchronous, active low; empties the table (fill level zero), slot data stays.
module packed_counted_key_table_unit #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pckt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pckt_pkg::out_t out_data
);

  localparam int unsigned UW = $clog2(SLOTS + 1);
  localparam int unsigned CW = (COUNT_BITS > pckt_pkg::AMOUNT_W) ?
                               COUNT_BITS : pckt_pkg::AMOUNT_W;
  localparam logic [UW-1:0] FULL_LEVEL = UW'(SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                        st_r;
  logic                        st_nxt;
  logic [1:0]                  cmd_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [pckt_pkg::AMOUNT_W-1:0] amount_r;
  logic [UW-1:0]               used_r;
  logic [UW-1:0]               used_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  pckt_pkg::out_t              out_data_r;
  pckt_pkg::out_t              out_data_nxt;
  pckt_pkg::cell_ctl_t         ctl;
  logic [KEY_BITS-1:0]         cmp_key;
  logic                        in_fire;
  logic                        exec_go;

  logic [KEY_BITS-1:0]   cell_key [SLOTS];
  logic [COUNT_BITS-1:0] cell_cnt [SLOTS];
  logic                  seen [SLOTS+1];
  logic [COUNT_BITS-1:0] gather [SLOTS+1];

  logic                  found;
  logic [COUNT_BITS-1:0] cur;
  logic [CW-1:0]         cur_w;
  logic [CW-1:0]         amt_w;
  logic [CW-1:0]         diff_w;
  logic [CW-1:0]         res_cnt;
  logic                  res_ok;

  assign in_ready = (st_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (st_r == S_EXEC) && (!out_valid_r || out_ready);

  // Cells compare against the arriving key, and later append the latched key.
  assign cmp_key = in_fire ? KEY_BITS'(in_data.key) : key_r;

  // Row of slot cells.
  assign seen[0]   = 1'b0;
  assign gather[0] = '0;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nk;
    logic [COUNT_BITS-1:0] nc;
    if (i + 1 < SLOTS) begin : g_link
      assign nk = cell_key[i+1];
      assign nc = cell_cnt[i+1];
    end else begin : g_end
      assign nk = '0;
      assign nc = '0;
    end
    pckt_cell #(
      .IDX        (i),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .UW         (UW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (cmp_key),
      .amount     (COUNT_BITS'(amount_r)),
      .used       (used_r),
      .next_key   (nk),
      .next_count (nc),
      .seen_in    (seen[i]),
      .cnt_in     (gather[i]),
      .key_out    (cell_key[i]),
      .count_out  (cell_cnt[i]),
      .seen_out   (seen[i+1]),
      .cnt_out    (gather[i+1])
    );
  end

  assign found  = seen[SLOTS];
  assign cur    = gather[SLOTS];
  assign cur_w  = CW'(cur);
  assign amt_w  = CW'(amount_r);
  assign diff_w = cur_w - amt_w;

  // Decide the command from the compare results and pick the cell operation.
  always_comb begin
    ctl.op   = pckt_pkg::OP_NONE;
    used_nxt = used_r;
    res_ok   = 1'b0;
    res_cnt  = cur_w;
    if (in_fire) begin
      ctl.op = pckt_pkg::OP_CMP;
    end else if (exec_go) begin
      priority if (cmd_r == pckt_pkg::CMD_ADD) begin
        if (found) begin
          if (cur != '1) begin
            ctl.op  = pckt_pkg::OP_INC;
            res_ok  = 1'b1;
            res_cnt = CW'(cur + 1'b1);
          end
        end else if (used_r < FULL_LEVEL) begin
          ctl.op   = pckt_pkg::OP_APPEND;
          used_nxt = used_r + 1'b1;
          res_ok   = 1'b1;
          res_cnt  = CW'(1);
        end else begin
          res_cnt = '0;
        end
      end else if (cmd_r == pckt_pkg::CMD_REMOVE) begin
        if (found && (cur_w >= amt_w)) begin
          res_ok  = 1'b1;
          res_cnt = diff_w;
          if (diff_w == '0) begin
            ctl.op   = pckt_pkg::OP_SHIFT;
            used_nxt = used_r - 1'b1;
          end else begin
            ctl.op = pckt_pkg::OP_SUB;
          end
        end
      end else begin
        res_ok = found && (cmd_r == pckt_pkg::CMD_QUERY);
      end
    end
  end

  // Sequencer and result register.
  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          st_nxt                = S_IDLE;
          out_valid_nxt         = 1'b1;
          out_data_nxt.ok       = res_ok;
          out_data_nxt.count    = pckt_pkg::COUNT_W'(res_cnt);
          out_data_nxt.used     = pckt_pkg::USED_W'(used_nxt);
          out_data_nxt.full_res = (used_nxt >= FULL_LEVEL);
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      cmd_r    <= in_data.cmd;
      key_r    <= KEY_BITS'(in_data.key);
      amount_r <= in_data.amount;
    end
    if (!rst_n) begin
      st_r        <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/pckt_checker.sv =====
// Port-level checks for the packed counted key table, bound to the top level.
module pckt_checker #(
  parameter int unsigned SLOTS = 16
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input pckt_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input pckt_pkg::out_t out_data
);

  // A waiting input item holds its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item changed");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The full flag only shows with the fill level at capacity.
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_res |-> out_data.used == pckt_pkg::USED_W'(SLOTS))
    else $error("full flag without full fill level");

  // The block is busy in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous one is in work");

  // A new result only appears after the block was busy with an item.
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a preceding item");

endmodule

bind packed_counted_key_table_unit pckt_checker #(
  .SLOTS (SLOTS)
) u_pckt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
